// ===== hdl/sqpc_pkg.sv =====
// Shared types, constants and helpers for the SUBLEQ processor core.
// No dependencies; the ALU, sequencer, top level and testbench import this package.
package sqpc_pkg;

   localparam int MEM_DEPTH_DEFAULT = 256;
   localparam int ALU_W             = 11;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int SIZE_W            = 9;

   localparam logic [SIZE_W-1:0] MEM_SIZE_RESET = 9'd256;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   // register index, taken from the upper address bits
   localparam logic [0:0] REG_MEMORY_SIZE = 1'b0;

   // operand B of this value prints memory[A]
   localparam logic signed [7:0] OPERAND_OUTPUT = -8'sd1;
   localparam logic [SIZE_W-1:0] PC_STEP        = 9'd3;
   // pc - size at or above this means pc+2 lies outside memory
   localparam logic signed [ALU_W-1:0] FETCH_MARGIN = -11'sd2;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type               op;
      logic signed [ALU_W-1:0]  x;
      logic signed [ALU_W-1:0]  y;
   } alu_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK_PC,
      ST_FETCH_B,
      ST_FETCH_C,
      ST_CHECK_A,
      ST_CHECK_B,
      ST_SUBTRACT,
      ST_TARGET,
      ST_BOUND,
      ST_REPLY
   } seq_state_type;

   function automatic logic signed [ALU_W-1:0] ext_u9(input logic [SIZE_W-1:0] v);
      return signed'({2'b00, v});
   endfunction

   function automatic logic signed [ALU_W-1:0] ext_s8(input logic [7:0] v);
      return signed'({{3{v[7]}}, v});
   endfunction

endpackage

// ===== hdl/sqpc_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing; used by the sequencer and the top level.
interface sqpc_req_if;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [7:0]        load_address;
   logic signed [7:0] load_value;

   modport source (output valid, mode, load_address, load_value, input ready);
   modport sink   (input valid, mode, load_address, load_value, output ready);
endinterface

interface sqpc_rsp_if;
   logic              valid;
   logic              ready;
   logic              char_valid;
   logic signed [7:0] char_out;
   logic              halted;
   logic [8:0]        pc_now;

   modport source (output valid, char_valid, char_out, halted, pc_now, input ready);
   modport sink   (input valid, char_valid, char_out, halted, pc_now, output ready);
endinterface

// ===== hdl/sqpc_mem.sv =====
// Single-port program memory with registered read data.
// Depends on nothing but its depth parameter.
module sqpc_mem #(
   parameter int MEM_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [$clog2(MEM_DEPTH)-1:0] addr,
   input  logic [7:0]                   wdata,
   output logic [7:0]                   rd_data_ff
);

   logic [7:0] mem_ff [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rd_data_ff <= mem_ff[addr];
   end

endmodule

// ===== hdl/sqpc_alu.sv =====
// Shared add/subtract unit; the bound checks against memory_size, fetch addresses, pc step and data update use it.
// Depends on sqpc_pkg.
module sqpc_alu (
   input  sqpc_pkg::alu_req_type                alu_req,
   output logic signed [sqpc_pkg::ALU_W-1:0]    alu_res
);
   import sqpc_pkg::*;

   always_comb begin
      case (alu_req.op)
         ALU_ADD: alu_res = alu_req.x + alu_req.y;
         ALU_SUB: alu_res = alu_req.x - alu_req.y;
         default: alu_res = alu_req.x;
      endcase
   end

endmodule

// ===== hdl/sqpc_ctrl.sv =====
// Instruction sequencer: handshakes, pc/halt state, operand registers, result word.
// Depends on sqpc_pkg, sqpc_if, and drives sqpc_alu and sqpc_mem from the top.
module sqpc_ctrl #(
   parameter int MEM_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sqpc_pkg::SIZE_W-1:0]        size,
   sqpc_req_if.sink                           req_port,
   sqpc_rsp_if.source                         rsp_port,
   output sqpc_pkg::alu_req_type              alu_req,
   input  logic signed [sqpc_pkg::ALU_W-1:0]  alu_res,
   output logic                               mem_we,
   output logic [$clog2(MEM_DEPTH)-1:0]       mem_addr,
   output logic [7:0]                         mem_wdata,
   input  logic [7:0]                         mem_rdata
);
   import sqpc_pkg::*;

   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam logic signed [ALU_W-1:0] OFFSET_B = 11'sd1;
   localparam logic signed [ALU_W-1:0] OFFSET_C = 11'sd2;

   seq_state_type     state_ff, state_in;
   logic [SIZE_W-1:0] pc_ff, pc_in;
   logic              halt_ff, halt_in;
   logic [7:0]        a_ff, a_in;
   logic signed [7:0] b_ff, b_in;
   logic [7:0]        c_ff, c_in;
   logic [7:0]        va_ff, va_in;
   logic              jump_ff, jump_in;
   logic              cv_ff, cv_in;
   logic [7:0]        co_ff, co_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_cv_ff, rsp_cv_in;
   logic [7:0]        rsp_co_ff, rsp_co_in;
   logic              rsp_halt_ff, rsp_halt_in;
   logic [SIZE_W-1:0] rsp_pc_ff, rsp_pc_in;
   logic              load_ok;
   logic [7:0]        diff8;

   assign load_ok = {1'b0, req_port.load_address} < SIZE_W'(MEM_DEPTH);
   assign diff8   = alu_res[7:0];

   assign req_port.ready      = (state_ff == ST_IDLE);
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.char_valid = rsp_cv_ff;
   assign rsp_port.char_out   = signed'(rsp_co_ff);
   assign rsp_port.halted     = rsp_halt_ff;
   assign rsp_port.pc_now     = rsp_pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      va_ff       <= va_in;
      jump_ff     <= jump_in;
      cv_ff       <= cv_in;
      co_ff       <= co_in;
      rsp_cv_ff   <= rsp_cv_in;
      rsp_co_ff   <= rsp_co_in;
      rsp_halt_ff <= rsp_halt_in;
      rsp_pc_ff   <= rsp_pc_in;
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      va_in        = va_ff;
      jump_in      = jump_ff;
      cv_in        = cv_ff;
      co_in        = co_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_co_in    = rsp_co_ff;
      rsp_halt_in  = rsp_halt_ff;
      rsp_pc_in    = rsp_pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      mem_we       = 1'b0;
      mem_addr     = pc_ff[ADDR_W-1:0];
      mem_wdata    = req_port.load_value;
      alu_req.op   = ALU_SUB;
      alu_req.x    = ext_u9(pc_ff);
      alu_req.y    = ext_u9(size);

      case (state_ff)
         ST_IDLE: begin
            // the read of memory[pc] started here feeds operand A
            if (req_port.valid) begin
               cv_in = 1'b0;
               co_in = '0;
               if (req_port.mode == MODE_LOAD) begin
                  mem_we   = load_ok;
                  mem_addr = req_port.load_address[ADDR_W-1:0];
                  pc_in    = '0;
                  halt_in  = 1'b0;
                  state_in = ST_REPLY;
               end else if (halt_ff) begin
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_CHECK_PC;
               end
            end
         end
         ST_CHECK_PC: begin
            a_in = mem_rdata;
            if (alu_res >= FETCH_MARGIN) begin
               halt_in  = 1'b1;
               state_in = ST_REPLY;
            end else begin
               state_in = ST_FETCH_B;
            end
         end
         ST_FETCH_B: begin
            alu_req.op = ALU_ADD;
            alu_req.y  = OFFSET_B;
            mem_addr   = alu_res[ADDR_W-1:0];
            state_in   = ST_FETCH_C;
         end
         ST_FETCH_C: begin
            alu_req.op = ALU_ADD;
            alu_req.y  = OFFSET_C;
            mem_addr   = alu_res[ADDR_W-1:0];
            b_in       = signed'(mem_rdata);
            state_in   = ST_CHECK_A;
         end
         ST_CHECK_A: begin
            c_in      = mem_rdata;
            alu_req.x = ext_s8(a_ff);
            mem_addr  = a_ff[ADDR_W-1:0];
            if (a_ff[7] || (b_ff < OPERAND_OUTPUT) || !alu_res[ALU_W-1]) begin
               halt_in  = 1'b1;
               state_in = ST_REPLY;
            end else begin
               state_in = ST_CHECK_B;
            end
         end
         ST_CHECK_B: begin
            va_in     = mem_rdata;
            alu_req.x = ext_s8(b_ff);
            mem_addr  = b_ff[ADDR_W-1:0];
            if (b_ff == OPERAND_OUTPUT) begin
               cv_in    = 1'b1;
               co_in    = mem_rdata;
               jump_in  = 1'b1;
               state_in = ST_TARGET;
            end else if (!alu_res[ALU_W-1]) begin
               halt_in  = 1'b1;
               state_in = ST_REPLY;
            end else begin
               state_in = ST_SUBTRACT;
            end
         end
         ST_SUBTRACT: begin
            alu_req.x = ext_s8(mem_rdata);
            alu_req.y = ext_s8(va_ff);
            mem_we    = 1'b1;
            mem_addr  = b_ff[ADDR_W-1:0];
            mem_wdata = diff8;
            jump_in   = diff8[7] || (diff8 == '0);
            state_in  = ST_TARGET;
         end
         ST_TARGET: begin
            alu_req.op = ALU_ADD;
            alu_req.y  = ext_u9(PC_STEP);
            if (jump_ff) begin
               if (c_ff[7]) begin
                  halt_in  = 1'b1;
                  state_in = ST_REPLY;
               end else begin
                  pc_in    = {1'b0, c_ff};
                  state_in = ST_BOUND;
               end
            end else begin
               pc_in    = alu_res[SIZE_W-1:0];
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            // leaving memory halts at once
            if (!alu_res[ALU_W-1]) begin
               halt_in = 1'b1;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cv_in    = cv_ff;
               rsp_co_in    = co_ff;
               rsp_halt_in  = halt_ff;
               rsp_pc_in    = pc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_load_resets_pc: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready && (req_port.mode == MODE_LOAD)
      |=> (pc_ff == '0) && !halt_ff)
      else $error("load word did not reset pc and halt");

   a_halted_step_holds_pc: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready && (req_port.mode == MODE_STEP) && halt_ff
      |=> $stable(pc_ff) && halt_ff)
      else $error("step while halted changed pc or halt");

   a_write_only_known_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SUBTRACT) || (state_ff == ST_IDLE))
      else $error("memory written outside load or subtract");

   a_result_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_REPLY)
      else $error("result word raised outside reply state");

endmodule

// ===== hdl/subleq_processor_core.sv =====
// Channel    Dir  Handshake     Word
// req_port   in   valid/ready   mode, load_address, load_value
// rsp_port   out  valid/ready   char_valid, char_out, halted, pc_now
// APB        in   psel/penable  memory_size at byte address 0
//
// A load word and a step while halted go straight from idle to the reply state.
// In a step the single memory port serves three operand fetches, two data reads and one write,
// and one shared adder does every bound check against memory_size, the pc step and the data update.
// Synchronous reset clears pc, halt and the sequencer; program memory stays
// undefined until loaded. A stalled result holds in its register; the next
// word is taken once the sequencer is back in idle.
module subleq_processor_core #(
   parameter int MEM_DEPTH = sqpc_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   sqpc_req_if.sink                            req_port,
   sqpc_rsp_if.source                          rsp_port,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sqpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [sqpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [sqpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import sqpc_pkg::*;

   localparam int ADDR_W = $clog2(MEM_DEPTH);

   logic [SIZE_W-1:0]       mem_size_ff, mem_size_in;
   logic [SIZE_W-1:0]       size_eff;
   logic                    reg_hit;
   alu_req_type             alu_req;
   logic signed [ALU_W-1:0] alu_res;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_addr;
   logic [7:0]              mem_wdata;
   logic [7:0]              mem_rdata;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[CSR_ADDR_W-1:2] == REG_MEMORY_SIZE);

   always_comb begin
      mem_size_in = mem_size_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         mem_size_in = pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff <= MEM_SIZE_RESET;
      end else begin
         mem_size_ff <= mem_size_in;
      end
   end

   assign prdata   = reg_hit ? {{(CSR_DATA_W-SIZE_W){1'b0}}, mem_size_ff} : '0;
   // saturate to the physical depth
   assign size_eff = (mem_size_ff > SIZE_W'(MEM_DEPTH)) ? SIZE_W'(MEM_DEPTH) : mem_size_ff;

   sqpc_ctrl #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .size      (size_eff),
      .req_port  (req_port),
      .rsp_port  (rsp_port),
      .alu_req   (alu_req),
      .alu_res   (alu_res),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   sqpc_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   sqpc_mem #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_mem (
      .clock      (clock),
      .we         (mem_we),
      .addr       (mem_addr),
      .wdata      (mem_wdata),
      .rd_data_ff (mem_rdata)
   );

endmodule

// ===== dv/tb_subleq_processor_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for subleq_processor_core: random SUBLEQ programs,
// random idling on both channels, memory_size rewritten between phases.
// Depends on hdl/sqpc_pkg.sv, hdl/sqpc_if.sv and the core RTL.
module tb_subleq_processor_core;
   import sqpc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PRINT_LIMIT = 40;
   localparam logic [CSR_ADDR_W-1:0] MEM_SIZE_ADDR = {REG_MEMORY_SIZE, 2'b00};

   // byte roles within an instruction
   localparam int ROLE_A = 0;
   localparam int ROLE_B = 1;
   localparam int ROLE_C = 2;

   typedef struct packed {
      logic       mode;
      logic [7:0] load_address;
      logic [7:0] load_value;
   } sq_cmd_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic       halted;
      logic [8:0] pc_now;
   } status_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   sqpc_req_if req_bus ();
   sqpc_rsp_if rsp_bus ();

   subleq_processor_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // machine image as the core should hold it
   logic [7:0] shadow_mem [256];
   logic [8:0] shadow_pc;
   bit         shadow_halt;
   logic [8:0] shadow_size;

   sq_cmd_type program_feed [$];
   status_type predicted_status [$];
   bit         loaded [256];

   sq_cmd_type cur_cmd;
   status_type due_status;
   int         feed_wait;
   int         rsp_hold;
   int         queued;
   int         reply_count;
   int         mismatch_count;
   int         cycle_count;
   bit         idle_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic status_type execute_subleq(input sq_cmd_type cmd);
      status_type s;
      int lim;
      int pc;
      int a;
      int b;
      int c;
      logic [7:0] diff;
      bit jump;
      s = '0;
      jump = 1'b0;
      if (cmd.mode == MODE_LOAD) begin
         shadow_mem[cmd.load_address] = cmd.load_value;
         shadow_pc = '0;
         shadow_halt = 1'b0;
      end else if (!shadow_halt) begin
         lim = (shadow_size > 256) ? 256 : int'(shadow_size);
         pc = int'(shadow_pc);
         if (pc + 2 >= lim) begin
            shadow_halt = 1'b1;
         end else begin
            a = $signed(shadow_mem[pc]);
            b = $signed(shadow_mem[pc + 1]);
            c = $signed(shadow_mem[pc + 2]);
            if (a < 0 || b < -1 || a >= lim) begin
               shadow_halt = 1'b1;
            end else if (b != -1 && b >= lim) begin
               shadow_halt = 1'b1;
            end else begin
               if (b == -1) begin
                  s.char_valid = 1'b1;
                  s.char_out = shadow_mem[a];
                  jump = 1'b1;
               end else begin
                  diff = shadow_mem[b] - shadow_mem[a];
                  shadow_mem[b] = diff;
                  jump = !($signed(diff) > 0);
               end
               if (jump && c < 0) begin
                  shadow_halt = 1'b1;
               end else begin
                  shadow_pc = jump ? 9'(c) : 9'(pc + 3);
                  if (int'(shadow_pc) >= lim) shadow_halt = 1'b1;
               end
            end
         end
      end
      s.halted = shadow_halt;
      s.pc_now = shadow_pc;
      return s;
   endfunction

   function automatic int draw_wait();
      return idle_on ? $urandom_range(0, 10) : 0;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("mismatch at reply %0d: %s", reply_count, what);
   endtask

   // driver: present one word at a time, with a drawn gap before the next
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         feed_wait = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predicted_status.insert(predicted_status.size(), execute_subleq(cur_cmd));
         if (!req_bus.valid || req_bus.ready) begin
            if (feed_wait != 0) begin
               req_bus.valid <= 1'b0;
               feed_wait--;
            end else if (program_feed.size() != 0) begin
               cur_cmd = program_feed.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.mode <= cur_cmd.mode;
               req_bus.load_address <= cur_cmd.load_address;
               req_bus.load_value <= cur_cmd.load_value;
               feed_wait = draw_wait();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each reply word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_status.size() == 0) begin
               flag_mismatch("reply word with nothing predicted");
            end else begin
               due_status = predicted_status.pop_front();
               if (rsp_bus.char_valid !== due_status.char_valid)
                  flag_mismatch($sformatf("char_valid %b, want %b",
                                          rsp_bus.char_valid, due_status.char_valid));
               if (rsp_bus.char_out !== due_status.char_out)
                  flag_mismatch($sformatf("char_out %h, want %h",
                                          rsp_bus.char_out, due_status.char_out));
               if (rsp_bus.halted !== due_status.halted)
                  flag_mismatch($sformatf("halted %b, want %b",
                                          rsp_bus.halted, due_status.halted));
               if (rsp_bus.pc_now !== due_status.pc_now)
                  flag_mismatch($sformatf("pc_now %0d, want %0d",
                                          rsp_bus.pc_now, due_status.pc_now));
            end
            reply_count++;
            rsp_hold = draw_wait();
         end
         if (rsp_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic queue_load(input int addr, input int value);
      program_feed.insert(program_feed.size(), {MODE_LOAD, 8'(addr), 8'(value)});
      loaded[addr & 255] = 1'b1;
      queued++;
   endtask

   task automatic queue_step();
      program_feed.insert(program_feed.size(), {MODE_STEP, 8'd0, 8'd0});
      queued++;
   endtask

   task automatic wait_idle();
      while (program_feed.size() != 0 || req_bus.valid || predicted_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_mem_size(input int value);
      wait_idle();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= MEM_SIZE_ADDR;
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      shadow_size = 9'(value);
   endtask

   // mostly in-range operands so programs run a while; the rest trip the halt checks
   function automatic logic [7:0] operand_byte(input int role, input int lim);
      int span;
      int roll;
      span = (lim < 128) ? lim : 128;
      if (lim < 3 || $urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      case (role)
         ROLE_A: begin
            if (roll < 88) return 8'($urandom_range(0, span - 1));
            if (roll < 94) return 8'($urandom_range(128, 255));
         end
         ROLE_B: begin
            if (roll < 30) return OPERAND_OUTPUT;
            if (roll < 84) return 8'($urandom_range(0, span - 1));
            if (roll < 92) return 8'($urandom_range(128, 254));
         end
         default: begin
            if (roll < 76) return 8'(3 * $urandom_range(0, (span - 1) / 3));
            if (roll < 88) return 8'($urandom_range(128, 255));
         end
      endcase
      // point past the end of memory where a positive byte can reach it
      return (lim < 128) ? 8'($urandom_range(lim, 127)) : 8'($urandom_range(0, 127));
   endfunction

   task automatic queue_program(input int lim);
      int body;
      int steps;
      body = (lim < 24) ? lim : $urandom_range(6, 24);
      for (int i = 0; i < body; i++) queue_load(i, operand_byte(i % 3, lim));
      steps = $urandom_range(2, 24);
      for (int i = 0; i < steps; i++) begin
         if ($urandom_range(0, 19) == 0)
            queue_load($urandom_range(0, 255), $urandom_range(0, 255));
         else
            queue_step();
      end
   endtask

   task automatic run_phase(input int size_value, input bit gaps, input int count);
      int lim;
      int stop;
      write_mem_size(size_value);
      idle_on = gaps;
      lim = (size_value > 256) ? 256 : size_value;
      // every byte a step may read must hold a loaded value
      for (int a = 0; a < lim; a++) begin
         if (!loaded[a]) queue_load(a, $urandom_range(0, 255));
      end
      stop = queued + count;
      while (queued < stop) begin
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) queue_step();
            else queue_load($urandom_range(0, 255), $urandom_range(0, 255));
         end else begin
            queue_program(lim);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_LOAD;
      req_bus.load_address = '0;
      req_bus.load_value = '0;
      rsp_bus.ready = 1'b0;
      shadow_pc = '0;
      shadow_halt = 1'b0;
      shadow_size = MEM_SIZE_RESET;
      idle_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty memory: pc is outside at once, then stays halted until a load
      write_mem_size(0);
      queue_load(255, -128);
      queue_step();
      queue_step();
      queue_load(0, 127);
      queue_step();
      // operand C would lie past the end
      write_mem_size(2);
      queue_load(1, 0);
      queue_step();
      // print and jump, subtract and advance, then A beyond the end
      write_mem_size(9);
      queue_load(0, 6);
      queue_load(1, -1);
      queue_load(2, 3);
      queue_load(3, 7);
      queue_load(4, 8);
      queue_load(5, -1);
      queue_load(6, 65);
      queue_load(7, 3);
      queue_load(8, 10);
      repeat (4) queue_step();
      // B below -1, negative A, then a print with a negative jump target
      queue_load(1, -2);
      queue_step();
      queue_load(0, -5);
      queue_step();
      queue_load(0, 6);
      queue_load(1, -1);
      queue_load(2, -3);
      queue_step();

      run_phase(16, 1'b1, 70);
      run_phase(9, 1'b0, 45);
      run_phase(1, 1'b1, 20);
      run_phase(3, 1'b1, 30);
      run_phase(40, 1'b0, 60);
      run_phase(0, 1'b1, 15);
      run_phase(128, 1'b1, 60);
      run_phase(511, 1'b0, 60);
      run_phase(256, 1'b1, 60);
      run_phase(300, 1'b1, 45);
      run_phase(24, 1'b0, 50);

      wait_idle();
      repeat (20) @(posedge clock);
      if (predicted_status.size() != 0) flag_mismatch("predicted reply never arrived");
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
